/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the camera pose block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cpbu_pkg.sv */
// Types, constants and helper functions of the camera pose block.
package cpbu_pkg;

   // fixed-point formats
   localparam int PosWidth    = 32;
   localparam int VecFrac     = 14;
   localparam int VecOne      = 1 << VecFrac;
   localparam int RootExtra   = 8;
   localparam int CordicFrac  = 30;
   localparam int RoundShift  = CordicFrac - VecFrac;
   localparam int CordicGain  = 652032874;
   localparam int CordicSteps = 16;
   localparam int AtanCount   = 24;
   localparam int CordicIters = (CordicSteps < AtanCount) ? CordicSteps : AtanCount;
   localparam int RootIters   = 24;
   localparam int QuotBits    = 31;

   // angle constants, 1/64 degree
   localparam int FullTurn    = 23040;
   localparam int HalfTurn    = 11520;
   localparam int QuarterTurn = 5760;
   localparam int YawHi       = 131071;
   localparam int YawLo       = -131072;
   localparam int ResetYaw    = 1280;

   // reset position, Q16.16
   localparam int ResetPosY   = 10 << 16;
   localparam int ResetPosZ   = 5 << 16;

   typedef enum logic [1:0] {
      OP_SET_ANGLES = 2'd0,
      OP_ADD_ANGLES = 2'd1,
      OP_MOVE       = 2'd2,
      OP_SET_POS    = 2'd3
   } op_type;

   typedef logic signed [15:0] vec_type;

   // arctangent of 2^-i in 2^-22 degree
   function automatic logic [27:0] atan_entry(input logic [4:0] i);
      logic [27:0] a;
      case (i)
         5'd0:    a = 28'd188743680;
         5'd1:    a = 28'd111421900;
         5'd2:    a = 28'd58872272;
         5'd3:    a = 28'd29884485;
         5'd4:    a = 28'd15000234;
         5'd5:    a = 28'd7507429;
         5'd6:    a = 28'd3754631;
         5'd7:    a = 28'd1877430;
         5'd8:    a = 28'd938729;
         5'd9:    a = 28'd469366;
         5'd10:   a = 28'd234683;
         5'd11:   a = 28'd117342;
         5'd12:   a = 28'd58671;
         5'd13:   a = 28'd29335;
         5'd14:   a = 28'd14668;
         5'd15:   a = 28'd7334;
         5'd16:   a = 28'd3667;
         5'd17:   a = 28'd1833;
         5'd18:   a = 28'd917;
         5'd19:   a = 28'd458;
         5'd20:   a = 28'd229;
         5'd21:   a = 28'd115;
         5'd22:   a = 28'd57;
         5'd23:   a = 28'd29;
         default: a = 28'd0;
      endcase
      return a;
   endfunction

   // clamp to +-1.0 in vector format
   function automatic vec_type clamp_vec(input logic signed [39:0] v);
      vec_type r;
      if (v > 40'(VecOne)) begin
         r = 16'(VecOne);
      end else if (v < -40'(VecOne)) begin
         r = -16'(VecOne);
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

/* rtl/core/camera_pose_basis_update.sv */
// Camera pose keeper: position, yaw, pitch and the derived basis vectors.
//
// Usage:
//   req channel: one item per command; req_tuser carries the operation
//   (set angles, add to angles, move along the camera axes, set position).
//   rsp channel: exactly one item per command with the pose after it.
// Work per command:
//   set position  : load the position, then the result item
//   move          : nine products through one multiplier
//   angle commands: two 16-step CORDIC runs, two 24-step square roots and
//   five 31-step divisions one after another, the squares and cross
//   products on one shared 16x32 multiplier, plus an angle reduction that
//   runs longer the further yaw and pitch lie outside one turn.
// One command is worked on at a time; req_tready is high only while idle.
// Reset: position (0, 10, 5), yaw 20 degrees, pitch 0. The basis vectors
// are then computed like an angle command with
// req_tready low and no result item.
// A result waits in its output register while the next command is taken;
// if the receiver still stalls when that command finishes, the block holds.
`include "assert_macros.svh"

module camera_pose_basis_update (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // yaw_angle, pitch_angle, move_right, move_down, move_forward, set_x, set_y, set_z
   input  logic [231:0] req_tdata,
   // operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // position_x/y/z, direction_x/y/z, right_x/y/z, down_x/y/z
   output logic [239:0] rsp_tdata
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_RED    = 10'b0000000010,
      S_CORDIC = 10'b0000000100,
      S_TRIG   = 10'b0000001000,
      S_SQ     = 10'b0000010000,
      S_ROOT   = 10'b0000100000,
      S_DIV    = 10'b0001000000,
      S_XPROD  = 10'b0010000000,
      S_MOVE   = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   typedef enum logic [2:0] {
      J_RX = 3'd0,
      J_RZ = 3'd1,
      J_DX = 3'd2,
      J_DY = 3'd3,
      J_DZ = 3'd4
   } job_type;

   // control
   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic boot_ff, boot_in;
   logic which_ff, which_in;
   logic neg_ff, neg_in;
   logic ph_ff, ph_in;
   logic root_sel_ff, root_sel_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] ax_ff, ax_in;
   logic rsp_valid_ff, rsp_valid_in;

   // pose state
   logic signed [17:0] yaw_ff, yaw_in;
   logic signed [13:0] pitch_ff, pitch_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   cpbu_pkg::vec_type dir_ff [3];
   cpbu_pkg::vec_type dir_in [3];
   cpbu_pkg::vec_type rgt_ff [3];
   cpbu_pkg::vec_type rgt_in [3];
   cpbu_pkg::vec_type dwn_ff [3];
   cpbu_pkg::vec_type dwn_in [3];

   // working registers
   logic signed [17:0] r_ff, r_in;
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] cz_ff, cz_in;
   logic signed [31:0] mr_ff, mr_in, md_ff, md_in, mf_ff, mf_in;
   logic signed [47:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [29:0] sq1_ff, sq1_in, sq2_ff, sq2_in;
   logic signed [30:0] c_ff [3];
   logic signed [30:0] c_in [3];
   logic [23:0] root1_ff, root1_in, root2_ff, root2_in;
   logic [47:0] sv_ff, sv_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [38:0] dn_ff, dn_in;
   logic [53:0] dd_ff, dd_in;
   logic [30:0] q_ff, q_in;
   logic qneg_ff, qneg_in;
   logic [239:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   cpbu_pkg::op_type   op;
   logic signed [16:0] in_yaw, in_pitch;
   logic signed [18:0] ny_sum, ny_wrap;
   logic signed [17:0] ny_sat;
   logic signed [17:0] np_sum;
   logic signed [13:0] np_clamp;
   logic signed [17:0] red_r2, red_r3;
   logic               red_neg;
   logic signed [32:0] cor_ys, cor_xs;
   logic signed [31:0] cor_at;
   logic signed [32:0] trig_y, trig_x;
   logic signed [33:0] trig_yr, trig_xr;
   cpbu_pkg::vec_type  trig_s, trig_c;
   logic signed [15:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [47:0] mul_p;
   logic signed [47:0] acc_sum;
   logic signed [47:0] mv_step;
   logic signed [34:0] mv_pos;
   logic signed [31:0] mv_sat;
   logic [47:0] rt_t;
   logic        rt_ge;
   logic [47:0] rt_v, rt_r;
   logic [23:0] root_d;
   logic signed [39:0] dv_num;
   logic [38:0] dv_mag;
   logic        dv_ge;
   logic [30:0] dv_q;
   logic [15:0] dv_qmag;
   cpbu_pkg::vec_type dv_val;

   assign op       = cpbu_pkg::op_type'(req_tuser);
   assign in_yaw   = signed'(req_tdata[16:0]);
   assign in_pitch = signed'(req_tdata[33:17]);

   // new yaw: wrap once, then saturate to 18 bits
   always_comb begin
      if (op == cpbu_pkg::OP_SET_ANGLES) begin
         ny_sum = 19'(in_yaw);
         np_sum = 18'(in_pitch);
      end else begin
         ny_sum = 19'(yaw_ff) + 19'(in_yaw);
         np_sum = 18'(pitch_ff) + 18'(in_pitch);
      end
      if (ny_sum > 19'(cpbu_pkg::FullTurn)) begin
         ny_wrap = ny_sum - 19'(cpbu_pkg::FullTurn);
      end else if (ny_sum < -19'(cpbu_pkg::FullTurn)) begin
         ny_wrap = ny_sum + 19'(cpbu_pkg::FullTurn);
      end else begin
         ny_wrap = ny_sum;
      end
      if (ny_wrap > 19'(cpbu_pkg::YawHi)) begin
         ny_sat = 18'(cpbu_pkg::YawHi);
      end else if (ny_wrap < 19'(cpbu_pkg::YawLo)) begin
         ny_sat = 18'(cpbu_pkg::YawLo);
      end else begin
         ny_sat = 18'(ny_wrap);
      end
      // pitch clamp to +-90 degrees
      if (np_sum > 18'(cpbu_pkg::QuarterTurn)) begin
         np_clamp = 14'(cpbu_pkg::QuarterTurn);
      end else if (np_sum < -18'(cpbu_pkg::QuarterTurn)) begin
         np_clamp = -14'(cpbu_pkg::QuarterTurn);
      end else begin
         np_clamp = 14'(np_sum);
      end
   end

   // fold reduced angle into [-90, 90]
   always_comb begin
      red_r2 = (r_ff > 18'(cpbu_pkg::HalfTurn)) ? r_ff - 18'(cpbu_pkg::FullTurn) : r_ff;
      red_neg = 1'b1;
      if (red_r2 > 18'(cpbu_pkg::QuarterTurn)) begin
         red_r3 = red_r2 - 18'(cpbu_pkg::HalfTurn);
      end else if (red_r2 < -18'(cpbu_pkg::QuarterTurn)) begin
         red_r3 = red_r2 + 18'(cpbu_pkg::HalfTurn);
      end else begin
         red_r3  = red_r2;
         red_neg = 1'b0;
      end
   end

   // CORDIC shift unit
   assign cor_ys = cy_ff >>> cnt_ff;
   assign cor_xs = cx_ff >>> cnt_ff;
   assign cor_at = signed'({4'b0000, cpbu_pkg::atan_entry(cnt_ff)});

   // CORDIC output rounding
   assign trig_y  = neg_ff ? -cy_ff : cy_ff;
   assign trig_x  = neg_ff ? -cx_ff : cx_ff;
   assign trig_yr = (34'(trig_y) + (34'sd1 <<< (cpbu_pkg::RoundShift - 1)))
                    >>> cpbu_pkg::RoundShift;
   assign trig_xr = (34'(trig_x) + (34'sd1 <<< (cpbu_pkg::RoundShift - 1)))
                    >>> cpbu_pkg::RoundShift;
   assign trig_s  = cpbu_pkg::clamp_vec(40'(trig_yr));
   assign trig_c  = cpbu_pkg::clamp_vec(40'(trig_xr));

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            case (cnt_ff[1:0])
               2'd0:    begin mul_a = dir_ff[0]; mul_b = 32'(dir_ff[0]); end
               2'd1:    begin mul_a = dir_ff[2]; mul_b = 32'(dir_ff[2]); end
               default: begin mul_a = dir_ff[1]; mul_b = 32'(dir_ff[1]); end
            endcase
         end
         S_XPROD: begin
            case (cnt_ff[1:0])
               2'd0:    begin mul_a = dir_ff[1]; mul_b = 32'(rgt_ff[2]); end
               2'd1:    begin mul_a = dir_ff[2]; mul_b = 32'(rgt_ff[0]); end
               2'd2:    begin mul_a = dir_ff[0]; mul_b = 32'(rgt_ff[2]); end
               default: begin mul_a = dir_ff[1]; mul_b = 32'(rgt_ff[0]); end
            endcase
         end
         S_MOVE: begin
            case (cnt_ff[1:0])
               2'd0:    begin mul_a = dwn_ff[ax_ff]; mul_b = md_ff; end
               2'd1:    begin mul_a = rgt_ff[ax_ff]; mul_b = mr_ff; end
               default: begin mul_a = dir_ff[ax_ff]; mul_b = mf_ff; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = 48'(mul_a) * 48'(mul_b);
   assign acc_sum = acc_ff + prod_ff;

   // move: round, add to position, saturate
   assign mv_step = (acc_sum + (48'sd1 <<< (cpbu_pkg::VecFrac - 1))) >>> cpbu_pkg::VecFrac;
   assign mv_pos  = 35'(pos_ff[ax_ff]) + 35'(mv_step);
   always_comb begin
      if (mv_pos > 35'((64'sd1 <<< (cpbu_pkg::PosWidth - 1)) - 64'sd1)) begin
         mv_sat = 32'((64'sd1 <<< (cpbu_pkg::PosWidth - 1)) - 64'sd1);
      end else if (mv_pos < -35'(64'sd1 <<< (cpbu_pkg::PosWidth - 1))) begin
         mv_sat = 32'(-(64'sd1 <<< (cpbu_pkg::PosWidth - 1)));
      end else begin
         mv_sat = 32'(mv_pos);
      end
   end

   // square root step
   assign rt_t  = sr_ff + sb_ff;
   assign rt_ge = sv_ff >= rt_t;
   assign rt_v  = rt_ge ? sv_ff - rt_t : sv_ff;
   assign rt_r  = rt_ge ? (sr_ff >> 1) + sb_ff : sr_ff >> 1;

   // divider operands
   assign root_d = ((job_ff == J_RX) || (job_ff == J_RZ)) ? root1_ff : root2_ff;
   always_comb begin
      case (job_ff)
         J_RX:    dv_num = 40'(-(17'(dir_ff[2]))) <<< (cpbu_pkg::VecFrac + cpbu_pkg::RootExtra);
         J_RZ:    dv_num = 40'(dir_ff[0]) <<< (cpbu_pkg::VecFrac + cpbu_pkg::RootExtra);
         J_DX:    dv_num = 40'(c_ff[0]) <<< cpbu_pkg::RootExtra;
         J_DY:    dv_num = 40'(c_ff[1]) <<< cpbu_pkg::RootExtra;
         default: dv_num = 40'(c_ff[2]) <<< cpbu_pkg::RootExtra;
      endcase
   end
   assign dv_mag  = dv_num[39] ? 39'(-dv_num) : 39'(dv_num);

   // restoring divide step, one quotient bit per cycle
   assign dv_ge   = 54'(dn_ff) >= dd_ff;
   assign dv_q    = {q_ff[29:0], dv_ge};
   assign dv_qmag = (dv_q > 31'(cpbu_pkg::VecOne)) ? 16'(cpbu_pkg::VecOne) : dv_q[15:0];
   always_comb begin
      if (root_d == '0) begin
         dv_val = '0;
      end else if (qneg_ff) begin
         dv_val = -signed'(dv_qmag);
      end else begin
         dv_val = signed'(dv_qmag);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      boot_in      = boot_ff;
      which_in     = which_ff;
      neg_in       = neg_ff;
      ph_in        = ph_ff;
      root_sel_in  = root_sel_ff;
      cnt_in       = cnt_ff;
      ax_in        = ax_ff;
      rsp_valid_in = rsp_valid_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      rgt_in       = rgt_ff;
      dwn_in       = dwn_ff;
      r_in         = r_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      mr_in        = mr_ff;
      md_in        = md_ff;
      mf_in        = mf_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      sq1_in       = sq1_ff;
      sq2_in       = sq2_ff;
      c_in         = c_ff;
      root1_in     = root1_ff;
      root2_in     = root2_ff;
      sv_in        = sv_ff;
      sr_in        = sr_ff;
      sb_in        = sb_ff;
      dn_in        = dn_ff;
      dd_in        = dd_ff;
      q_in         = q_ff;
      qneg_in      = qneg_ff;
      rsp_data_in  = rsp_data_ff;

      // result item taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (op)
                  cpbu_pkg::OP_SET_ANGLES, cpbu_pkg::OP_ADD_ANGLES: begin
                     yaw_in   = ny_sat;
                     pitch_in = np_clamp;
                     r_in     = ny_sat;
                     which_in = 1'b0;
                     state_in = S_RED;
                  end
                  cpbu_pkg::OP_MOVE: begin
                     mr_in    = signed'(req_tdata[65:34]);
                     md_in    = signed'(req_tdata[97:66]);
                     mf_in    = signed'(req_tdata[129:98]);
                     ax_in    = 2'd0;
                     cnt_in   = '0;
                     ph_in    = 1'b0;
                     acc_in   = '0;
                     state_in = S_MOVE;
                  end
                  cpbu_pkg::OP_SET_POS: begin
                     pos_in[0] = signed'(req_tdata[161:130]);
                     pos_in[1] = signed'(req_tdata[193:162]);
                     pos_in[2] = signed'(req_tdata[225:194]);
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // angle reduction into [0, 360), then fold and start CORDIC
         S_RED: begin
            if (r_ff[17]) begin
               r_in = r_ff + 18'(cpbu_pkg::FullTurn);
            end else if (r_ff >= 18'(cpbu_pkg::FullTurn)) begin
               r_in = r_ff - 18'(cpbu_pkg::FullTurn);
            end else begin
               neg_in   = red_neg;
               cz_in    = 32'(red_r3) <<< 16;
               cx_in    = 33'(cpbu_pkg::CordicGain);
               cy_in    = '0;
               cnt_in   = '0;
               state_in = S_CORDIC;
            end
         end

         S_CORDIC: begin
            if (!cz_ff[31]) begin
               cx_in = cx_ff - cor_ys;
               cy_in = cy_ff + cor_xs;
               cz_in = cz_ff - cor_at;
            end else begin
               cx_in = cx_ff + cor_ys;
               cy_in = cy_ff - cor_xs;
               cz_in = cz_ff + cor_at;
            end
            if (cnt_ff == 5'(cpbu_pkg::CordicIters - 1)) begin
               state_in = S_TRIG;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end

         S_TRIG: begin
            if (!which_ff) begin
               dir_in[0] = trig_s;
               dir_in[2] = -trig_c;
               r_in      = 18'(pitch_ff);
               which_in  = 1'b1;
               state_in  = S_RED;
            end else begin
               dir_in[1] = -trig_s;
               cnt_in    = '0;
               ph_in     = 1'b0;
               acc_in    = '0;
               state_in  = S_SQ;
            end
         end

         // squared lengths: dx^2 + dz^2, then + dy^2
         S_SQ: begin
            if (!ph_ff) begin
               prod_in = mul_p;
               ph_in   = 1'b1;
            end else begin
               acc_in = acc_sum;
               ph_in  = 1'b0;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd1) begin
                  sq1_in = acc_sum[29:0];
               end
               if (cnt_ff == 5'd2) begin
                  sq2_in      = acc_sum[29:0];
                  root_sel_in = 1'b0;
                  state_in    = S_ROOT;
               end
            end
         end

         S_ROOT: begin
            if (!ph_ff) begin
               sv_in  = (root_sel_ff ? 48'(sq2_ff) : 48'(sq1_ff)) << 16;
               sr_in  = '0;
               sb_in  = 48'd1 << (2 * (cpbu_pkg::RootIters - 1));
               cnt_in = 5'(cpbu_pkg::RootIters - 1);
               ph_in  = 1'b1;
            end else begin
               sv_in = rt_v;
               sr_in = rt_r;
               sb_in = sb_ff >> 2;
               if (cnt_ff == '0) begin
                  ph_in = 1'b0;
                  if (!root_sel_ff) begin
                     root1_in = rt_r[23:0];
                     job_in   = J_RX;
                  end else begin
                     root2_in = rt_r[23:0];
                     job_in   = J_DX;
                  end
                  state_in = S_DIV;
               end else begin
                  cnt_in = cnt_ff - 5'd1;
               end
            end
         end

         S_DIV: begin
            if (!ph_ff) begin
               qneg_in = dv_num[39];
               dn_in   = dv_mag + 39'(root_d >> 1);
               dd_in   = 54'(root_d) << (cpbu_pkg::QuotBits - 1);
               q_in    = '0;
               cnt_in  = 5'(cpbu_pkg::QuotBits - 1);
               ph_in   = 1'b1;
            end else begin
               dn_in = dv_ge ? 39'(54'(dn_ff) - dd_ff) : dn_ff;
               dd_in = dd_ff >> 1;
               q_in  = dv_q;
               if (cnt_ff == '0) begin
                  ph_in = 1'b0;
                  unique case (job_ff)
                     J_RX: begin
                        rgt_in[0] = dv_val;
                        rgt_in[1] = '0;
                        job_in    = J_RZ;
                     end
                     J_RZ: begin
                        rgt_in[2] = dv_val;
                        cnt_in    = '0;
                        state_in  = S_XPROD;
                     end
                     J_DX: begin
                        dwn_in[0] = dv_val;
                        job_in    = J_DY;
                     end
                     J_DY: begin
                        dwn_in[1] = dv_val;
                        job_in    = J_DZ;
                     end
                     J_DZ: begin
                        dwn_in[2] = dv_val;
                        boot_in   = 1'b0;
                        state_in  = boot_ff ? S_IDLE : S_DONE;
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end else begin
                  cnt_in = cnt_ff - 5'd1;
               end
            end
         end

         // d x right: c0 = dy*rz, c1 = dz*rx - dx*rz, c2 = -dy*rx
         S_XPROD: begin
            if (!ph_ff) begin
               prod_in = mul_p;
               ph_in   = 1'b1;
            end else begin
               ph_in  = 1'b0;
               cnt_in = cnt_ff + 5'd1;
               case (cnt_ff[1:0])
                  2'd0:    c_in[0] = 31'(prod_ff);
                  2'd1:    acc_in  = prod_ff;
                  2'd2:    c_in[1] = 31'(acc_ff - prod_ff);
                  default: begin
                     c_in[2]     = 31'(-prod_ff);
                     root_sel_in = 1'b1;
                     state_in    = S_ROOT;
                  end
               endcase
            end
         end

         // per axis: down*md + right*mr + dir*mf
         S_MOVE: begin
            if (!ph_ff) begin
               prod_in = mul_p;
               ph_in   = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (cnt_ff == 5'd2) begin
                  pos_in[ax_ff] = mv_sat;
                  acc_in        = '0;
                  cnt_in        = '0;
                  if (ax_ff == 2'd2) begin
                     state_in = S_DONE;
                  end else begin
                     ax_in = ax_ff + 2'd1;
                  end
               end else begin
                  acc_in = acc_sum;
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end

         // load output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {dwn_ff[2], dwn_ff[1], dwn_ff[0],
                               rgt_ff[2], rgt_ff[1], rgt_ff[0],
                               dir_ff[2], dir_ff[1], dir_ff[0],
                               pos_ff[2], pos_ff[1], pos_ff[0]};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RED;
         job_ff       <= J_RX;
         boot_ff      <= 1'b1;
         which_ff     <= 1'b0;
         neg_ff       <= 1'b0;
         ph_ff        <= 1'b0;
         root_sel_ff  <= 1'b0;
         cnt_ff       <= '0;
         ax_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         yaw_ff       <= 18'(cpbu_pkg::ResetYaw);
         pitch_ff     <= '0;
         r_ff         <= 18'(cpbu_pkg::ResetYaw);
         pos_ff[0]    <= '0;
         pos_ff[1]    <= 32'(cpbu_pkg::ResetPosY);
         pos_ff[2]    <= 32'(cpbu_pkg::ResetPosZ);
         for (int k = 0; k < 3; k++) begin
            dir_ff[k] <= '0;
            rgt_ff[k] <= '0;
            dwn_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         boot_ff      <= boot_in;
         which_ff     <= which_in;
         neg_ff       <= neg_in;
         ph_ff        <= ph_in;
         root_sel_ff  <= root_sel_in;
         cnt_ff       <= cnt_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         r_ff         <= r_in;
         pos_ff       <= pos_in;
         dir_ff       <= dir_in;
         rgt_ff       <= rgt_in;
         dwn_ff       <= dwn_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      mr_ff       <= mr_in;
      md_ff       <= md_in;
      mf_ff       <= mf_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sq1_ff      <= sq1_in;
      sq2_ff      <= sq2_in;
      c_ff        <= c_in;
      root1_ff    <= root1_in;
      root2_ff    <= root2_in;
      sv_ff       <= sv_in;
      sr_ff       <= sr_in;
      sb_ff       <= sb_in;
      dn_ff       <= dn_in;
      dd_ff       <= dd_in;
      q_ff        <= q_in;
      qneg_ff     <= qneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `ASSERT_CLK(a_right_level, rgt_ff[1] == 16'sd0, "right vector has a y component")
   `ASSERT_CLK(a_pitch_range, (pitch_ff <= 14'sd5760) && (pitch_ff >= -14'sd5760), "pitch out of range")
   `ASSERT_CLK(a_boot_quiet, boot_ff |-> !rsp_tvalid, "result item during start-up")

endmodule

/* verif/camera_pose_basis_update_tb.sv */
// Testbench for camera_pose_basis_update: directed and random pose commands checked against a built-in pose predictor.
`timescale 1ns / 100ps

module camera_pose_basis_update_tb;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 400;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // yaw_angle, pitch_angle, move_right, move_down, move_forward, set_x, set_y, set_z
   logic [231:0] req_tdata;
   // operation
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // position_x/y/z, direction_x/y/z, right_x/y/z, down_x/y/z
   logic [239:0] rsp_tdata;

   camera_pose_basis_update dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // arctangent of 2^-i in 2^-22 degree
   localparam longint AtanTable [24] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29
   };

   // predicted camera state
   longint cam_pos [3];
   int     cam_yaw;
   int     cam_pitch;
   longint cam_dir [3];
   longint cam_right [3];
   longint cam_down [3];

   logic [239:0] pose_queue [$];
   int           mismatch_count;
   int           idle_cycles;
   int           burst_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v > cpbu_pkg::VecOne) return cpbu_pkg::VecOne;
      if (v < -cpbu_pkg::VecOne) return -cpbu_pkg::VecOne;
      return v;
   endfunction

   function automatic longint sat_pos(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint div_round(input longint n, input longint d);
      if (d <= 0) return 0;
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint int_root(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // CORDIC sine and cosine of an angle in 1/64 degree
   task automatic angle_sin_cos(input int a, output longint s, output longint c);
      int     r;
      bit     neg;
      longint x, y, z, xs, ys;
      r = a % cpbu_pkg::FullTurn;
      neg = 1'b0;
      x = cpbu_pkg::CordicGain;
      y = 0;
      if (r < 0) r += cpbu_pkg::FullTurn;
      if (r > cpbu_pkg::HalfTurn) r -= cpbu_pkg::FullTurn;
      if (r > cpbu_pkg::QuarterTurn) begin
         r -= cpbu_pkg::HalfTurn;
         neg = 1'b1;
      end else if (r < -cpbu_pkg::QuarterTurn) begin
         r += cpbu_pkg::HalfTurn;
         neg = 1'b1;
      end
      z = longint'(r) * 65536;
      for (int i = 0; i < cpbu_pkg::CordicIters; i++) begin
         ys = y >>> i;
         xs = x >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= AtanTable[i];
         end else begin
            x += ys; y -= xs; z += AtanTable[i];
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      s = clamp_unit(round_shift(y, cpbu_pkg::RoundShift));
      c = clamp_unit(round_shift(x, cpbu_pkg::RoundShift));
   endtask

   // recompute direction, right and down from the angles
   task automatic update_basis();
      longint sy, cy, sp, cp, dx, dy, dz, rx, rz, root, c0, c1, c2;
      longint scale;
      scale = longint'(1) << (cpbu_pkg::VecFrac + cpbu_pkg::RootExtra);
      angle_sin_cos(cam_yaw, sy, cy);
      angle_sin_cos(cam_pitch, sp, cp);
      dx = sy; dy = -sp; dz = -cy;
      cam_dir = '{dx, dy, dz};
      root = int_root(longint'(dx * dx + dz * dz) << 16);
      if (root == 0) begin
         rx = 0; rz = 0;
      end else begin
         rx = clamp_unit(div_round(-dz * scale, root));
         rz = clamp_unit(div_round(dx * scale, root));
      end
      cam_right = '{rx, 0, rz};
      root = int_root(longint'(dx * dx + dy * dy + dz * dz) << 16);
      if (root == 0) begin
         cam_down = '{0, 0, 0};
      end else begin
         c0 = dy * rz;
         c1 = dz * rx - dx * rz;
         c2 = -dy * rx;
         cam_down[0] = clamp_unit(div_round(c0 << cpbu_pkg::RootExtra, root));
         cam_down[1] = clamp_unit(div_round(c1 << cpbu_pkg::RootExtra, root));
         cam_down[2] = clamp_unit(div_round(c2 << cpbu_pkg::RootExtra, root));
      end
   endtask

   // yaw wraps once then saturates, pitch clamps
   task automatic apply_angles(input longint ny, input longint np);
      if (ny > cpbu_pkg::FullTurn) ny -= cpbu_pkg::FullTurn;
      else if (ny < -cpbu_pkg::FullTurn) ny += cpbu_pkg::FullTurn;
      if (ny > cpbu_pkg::YawHi) ny = cpbu_pkg::YawHi;
      if (ny < cpbu_pkg::YawLo) ny = cpbu_pkg::YawLo;
      if (np > cpbu_pkg::QuarterTurn) np = cpbu_pkg::QuarterTurn;
      if (np < -cpbu_pkg::QuarterTurn) np = -cpbu_pkg::QuarterTurn;
      cam_yaw = int'(ny);
      cam_pitch = int'(np);
      update_basis();
   endtask

   // advance the predicted pose by one command and return the result item
   task automatic predict_pose(input cpbu_pkg::op_type op, input logic [231:0] d,
                               output logic [239:0] pose);
      longint ya, pa, mr, md, mf, acc;
      ya = longint'($signed(d[16:0]));
      pa = longint'($signed(d[33:17]));
      mr = longint'($signed(d[65:34]));
      md = longint'($signed(d[97:66]));
      mf = longint'($signed(d[129:98]));
      case (op)
         cpbu_pkg::OP_SET_ANGLES: apply_angles(ya, pa);
         cpbu_pkg::OP_ADD_ANGLES: apply_angles(cam_yaw + ya, cam_pitch + pa);
         cpbu_pkg::OP_MOVE: begin
            for (int k = 0; k < 3; k++) begin
               acc = cam_down[k] * md + cam_right[k] * mr + cam_dir[k] * mf;
               cam_pos[k] = sat_pos(cam_pos[k] + round_shift(acc, cpbu_pkg::VecFrac));
            end
         end
         default: begin
            for (int k = 0; k < 3; k++)
               cam_pos[k] = longint'($signed(d[130 + 32 * k +: 32]));
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         pose[32 * k +: 32]       = cam_pos[k][31:0];
         pose[96 + 16 * k +: 16]  = cam_dir[k][15:0];
         pose[144 + 16 * k +: 16] = cam_right[k][15:0];
         pose[192 + 16 * k +: 16] = cam_down[k][15:0];
      end
   endtask

   // send one command, sender works in bursts with random gaps
   task automatic send_cmd(input cpbu_pkg::op_type op, input int ya, input int pa,
                           input int mr, input int md, input int mf,
                           input int sx, input int sy, input int sz);
      logic [231:0] d;
      logic [239:0] pose;
      d = {6'd0, sz, sy, sx, mf, md, mr, pa[16:0], ya[16:0]};
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_pose(op, d, pose);
      pose_queue.push_back(pose);
   endtask

   function automatic int rand_angle();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 65535 : -65536;
         1: return int'($urandom_range(0, 46080)) - 23040;
         2: return int'($urandom_range(0, 11520)) - 5760;
         3: return $urandom_range(0, 1) ? 23041 : -23041;
         default: return int'({{15{1'b0}}, 17'($urandom)} << 15) >>> 15;
      endcase
   endfunction

   function automatic int rand_amount();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   function automatic cpbu_pkg::op_type rand_op();
      case ($urandom_range(0, 9))
         0, 1: return cpbu_pkg::OP_SET_ANGLES;
         2, 3: return cpbu_pkg::OP_ADD_ANGLES;
         4, 5, 6, 7: return cpbu_pkg::OP_MOVE;
         default: return cpbu_pkg::OP_SET_POS;
      endcase
   endfunction

   // receiver stall pattern: stretches with no stalls, light stalls and heavy stalls
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if ((($time / 4) / 700) % 2 == 1)
            rsp_tready <= ($urandom_range(0, 3) != 0);
         else if ((($time / 4) / 700) % 4 == 2)
            rsp_tready <= ($urandom_range(0, 7) == 0);
         else
            rsp_tready <= 1'b1;
      end
   end

   // result check
   always @(posedge clock) begin
      logic [239:0] want;
      int           lo, w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item %h", rsp_tdata);
         end else begin
            want = pose_queue.pop_front();
            for (int f = 0; f < 12; f++) begin
               lo = (f < 3) ? 32 * f : 96 + 16 * (f - 3);
               w  = (f < 3) ? 32 : 16;
               if (((want ^ rsp_tdata) >> lo) & ((240'd1 << w) - 1)) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("field %0d mismatch: expected %h got %h", f,
                              (want >> lo) & ((240'd1 << w) - 1),
                              (rsp_tdata >> lo) & ((240'd1 << w) - 1));
               end
            end
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_set_position();
      send_cmd(cpbu_pkg::OP_SET_POS, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
      send_cmd(cpbu_pkg::OP_SET_POS, -1, -1, -1, -1, -1, 32'h80000000, 32'h7fffffff, -1);
      send_cmd(cpbu_pkg::OP_SET_POS, 0, 0, 0, 0, 0, 0, 10 << 16, 5 << 16);
   endtask

   task automatic test_angle_limits();
      send_cmd(cpbu_pkg::OP_SET_ANGLES, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, 23041, 5761, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, -23041, -5761, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, 65535, -65536, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, -65536, 65535, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, 11520, 5760, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, -11520, -5760, 0, 0, 0, 0, 0, 0);
      // repeated adds drive yaw into saturation
      repeat (5) send_cmd(cpbu_pkg::OP_ADD_ANGLES, 65535, 65535, 0, 0, 0, 0, 0, 0);
      repeat (5) send_cmd(cpbu_pkg::OP_ADD_ANGLES, -65536, -65536, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_move();
      send_cmd(cpbu_pkg::OP_MOVE, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_MOVE, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_MOVE, 0, 0, 1 << 16, -(1 << 16), 3 << 16, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_SET_ANGLES, 2000, -1000, 0, 0, 0, 0, 0, 0);
      send_cmd(cpbu_pkg::OP_MOVE, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
   endtask

   // hold off until every result is back
   task automatic test_drain_pause();
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (pose_queue.size() == 0);
      @(posedge clock);
   endtask

   task automatic test_random(input int count);
      int p;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(0, 99);
         if (p < 3) send_cmd(rand_op(), $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
         else
            send_cmd(rand_op(), rand_angle(), rand_angle(), rand_amount(),
                     rand_amount(), rand_amount(), rand_amount(), rand_amount(),
                     rand_amount());
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = cpbu_pkg::OP_SET_ANGLES;
      mismatch_count = 0;
      idle_cycles    = 0;
      burst_left     = 0;
      cam_pos        = '{0, 10 << 16, 5 << 16};
      apply_angles(cpbu_pkg::ResetYaw, 0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // first move checks the basis computed after reset
      send_cmd(cpbu_pkg::OP_MOVE, 0, 0, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0);
      test_set_position();
      test_angle_limits();
      test_move();
      test_drain_pause();
      test_random(900);
      test_drain_pause();
      test_random(900);

      req_tvalid <= 1'b0;
      wait (pose_queue.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pose_queue.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cpbu_pkg.sv
rtl/core/camera_pose_basis_update.sv
verif/camera_pose_basis_update_tb.sv
